// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker module of the sparse set index table.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define SSIT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while the active-low reset is asserted.
`define SSIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/ssit_pkg.sv =====
// Package of the sparse set index table: sizes, codes, payload and request types.
// Depends on nothing; used by every module of the block.
`default_nettype none

package ssit_pkg;

  localparam int ENTITIES = 1024;
  localparam int SLOTS    = 256;

  localparam int ENT_W  = $clog2(ENTITIES);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam int CLR_DEPTH = (ENTITIES > SLOTS) ? ENTITIES : SLOTS;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_LOOKUP  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_PRESENT = 2'd1,
    STAT_ABSENT  = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [ENT_W-1:0] entity;
  } in_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [ENT_W-1:0]  moved_entity;
    logic              moved;
    logic [CNT_W-1:0]  used_count;
  } out_t;

  typedef struct packed {
    logic              re;
    logic [ENT_W-1:0]  raddr;
    logic              we;
    logic [ENT_W-1:0]  waddr;
    logic [SLOT_W-1:0] wdata;
  } sparse_req_t;

  typedef struct packed {
    logic              re;
    logic [SLOT_W-1:0] raddr_a;
    logic [SLOT_W-1:0] raddr_b;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [ENT_W-1:0]  wdata;
  } dense_req_t;

endpackage

`default_nettype wire

// ===== src/sparse_set_index_table_top.sv =====
// Sparse set index table, top level: mapping of entity ids to packed slots with
// create, destroy and lookup. The sparse table is read on acceptance, the dense
// table is read at the entity's slot and at the last used slot in the next cycle
// (ST_READ), and the update and result follow in ST_EXEC. The result waits in an
// output register, so the next transaction is accepted while it is pending; the
// update cycle holds until that register is free. After reset a clearing pass
// zeroes both tables, during which in_ready_o is low.
// Depends on ssit_pkg, ssit_sparse_mem, ssit_dense_mem and ssit_ctrl.
`default_nettype none

module sparse_set_index_table_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ssit_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ssit_pkg::out_t      out_data_o
);

  ssit_pkg::sparse_req_t        sp_req;
  ssit_pkg::dense_req_t         dn_req;
  logic [ssit_pkg::SLOT_W-1:0]  sp_rdata;
  logic [ssit_pkg::ENT_W-1:0]   dn_rdata_a;
  logic [ssit_pkg::ENT_W-1:0]   dn_rdata_b;

  ssit_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .sp_req_o     (sp_req),
    .sp_rdata_i   (sp_rdata),
    .dn_req_o     (dn_req),
    .dn_rdata_a_i (dn_rdata_a),
    .dn_rdata_b_i (dn_rdata_b)
  );

  ssit_sparse_mem u_sparse (
    .clk_i   (clk_i),
    .req_i   (sp_req),
    .rdata_o (sp_rdata)
  );

  ssit_dense_mem u_dense (
    .clk_i     (clk_i),
    .req_i     (dn_req),
    .rdata_a_o (dn_rdata_a),
    .rdata_b_o (dn_rdata_b)
  );

endmodule

`default_nettype wire

// ===== src/ssit_sparse_mem.sv =====
// Sparse table memory: slot of each entity, one write and one registered read port.
// Depends on ssit_pkg for sizes and the request struct.
`default_nettype none

module ssit_sparse_mem (
  input  wire logic                          clk_i,
  input  wire ssit_pkg::sparse_req_t         req_i,
  output logic [ssit_pkg::SLOT_W-1:0]        rdata_o
);

  logic [ssit_pkg::SLOT_W-1:0] mem_q [ssit_pkg::ENTITIES];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem_q[req_i.raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/ssit_dense_mem.sv =====
// Dense table memory: entity of each slot, one write and two registered read ports.
// Depends on ssit_pkg for sizes and the request struct.
`default_nettype none

module ssit_dense_mem (
  input  wire logic                         clk_i,
  input  wire ssit_pkg::dense_req_t         req_i,
  output logic [ssit_pkg::ENT_W-1:0]        rdata_a_o,
  output logic [ssit_pkg::ENT_W-1:0]        rdata_b_o
);

  logic [ssit_pkg::ENT_W-1:0] mem_q [ssit_pkg::SLOTS];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_a_o <= mem_q[req_i.raddr_a];
      rdata_b_o <= mem_q[req_i.raddr_b];
    end
  end

endmodule

`default_nettype wire

// ===== src/ssit_ctrl.sv =====
// Sequencer of the sparse set index table: clearing pass, read-modify-write and result register.
// Depends on ssit_pkg; drives the sparse and dense memories.
`default_nettype none

module ssit_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire ssit_pkg::in_t               in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output ssit_pkg::out_t                   out_data_o,
  output ssit_pkg::sparse_req_t            sp_req_o,
  input  wire logic [ssit_pkg::SLOT_W-1:0] sp_rdata_i,
  output ssit_pkg::dense_req_t             dn_req_o,
  input  wire logic [ssit_pkg::ENT_W-1:0]  dn_rdata_a_i,
  input  wire logic [ssit_pkg::ENT_W-1:0]  dn_rdata_b_i
);

  ssit_pkg::state_e              state_q, state_d;
  logic [ssit_pkg::CLR_W-1:0]    clr_q, clr_d;
  logic [ssit_pkg::CNT_W-1:0]    count_q, count_d;
  logic [1:0]                    cmd_q;
  logic [ssit_pkg::ENT_W-1:0]    ent_q;
  logic                          out_valid_q, out_valid_d;
  ssit_pkg::out_t                out_q, out_d;

  logic                          accept;
  logic                          fire;
  logic                          present;
  logic [ssit_pkg::CNT_W-1:0]    last;
  logic [ssit_pkg::SLOT_W-1:0]   last_slot;

  assign accept     = in_valid_i && (state_q == ssit_pkg::ST_IDLE);
  assign fire       = (state_q == ssit_pkg::ST_EXEC) && (!out_valid_q || out_ready_i);
  assign last       = count_q - ssit_pkg::CNT_W'(1);
  assign last_slot  = last[ssit_pkg::SLOT_W-1:0];
  assign present    = ({1'b0, sp_rdata_i} < count_q) && (dn_rdata_a_i == ent_q);

  assign in_ready_o  = (state_q == ssit_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    sp_req_o       = '0;
    sp_req_o.raddr = in_data_i.entity;
    dn_req_o         = '0;
    dn_req_o.raddr_a = sp_rdata_i;
    dn_req_o.raddr_b = last_slot;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ssit_pkg::ST_CLEAR: begin
        sp_req_o.we    = 32'(clr_q) < ssit_pkg::ENTITIES;
        sp_req_o.waddr = clr_q[ssit_pkg::ENT_W-1:0];
        dn_req_o.we    = 32'(clr_q) < ssit_pkg::SLOTS;
        dn_req_o.waddr = clr_q[ssit_pkg::SLOT_W-1:0];
        clr_d          = clr_q + ssit_pkg::CLR_W'(1);
        if (32'(clr_q) == ssit_pkg::CLR_DEPTH - 1) begin
          state_d = ssit_pkg::ST_IDLE;
        end
      end
      ssit_pkg::ST_IDLE: begin
        sp_req_o.re = accept;
        if (accept) begin
          state_d = ssit_pkg::ST_READ;
        end
      end
      ssit_pkg::ST_READ: begin
        dn_req_o.re = 1'b1;
        state_d     = ssit_pkg::ST_EXEC;
      end
      ssit_pkg::ST_EXEC: begin
        if (fire) begin
          state_d            = ssit_pkg::ST_IDLE;
          out_valid_d        = 1'b1;
          out_d.status       = ssit_pkg::STAT_ABSENT;
          out_d.slot         = '0;
          out_d.moved_entity = '0;
          out_d.moved        = 1'b0;
          case (cmd_q)
            ssit_pkg::CMD_CREATE: begin
              if (present) begin
                out_d.status = ssit_pkg::STAT_PRESENT;
                out_d.slot   = sp_rdata_i;
              end else if (32'(count_q) >= ssit_pkg::SLOTS) begin
                out_d.status = ssit_pkg::STAT_FULL;
              end else begin
                sp_req_o.we    = 1'b1;
                sp_req_o.waddr = ent_q;
                sp_req_o.wdata = count_q[ssit_pkg::SLOT_W-1:0];
                dn_req_o.we    = 1'b1;
                dn_req_o.waddr = count_q[ssit_pkg::SLOT_W-1:0];
                dn_req_o.wdata = ent_q;
                count_d        = count_q + ssit_pkg::CNT_W'(1);
                out_d.status   = ssit_pkg::STAT_DONE;
                out_d.slot     = count_q[ssit_pkg::SLOT_W-1:0];
              end
            end
            ssit_pkg::CMD_DESTROY: begin
              if (present) begin
                sp_req_o.we    = 1'b1;
                sp_req_o.waddr = dn_rdata_b_i;
                sp_req_o.wdata = sp_rdata_i;
                dn_req_o.we    = 1'b1;
                dn_req_o.waddr = sp_rdata_i;
                dn_req_o.wdata = dn_rdata_b_i;
                count_d        = last;
                out_d.status   = ssit_pkg::STAT_DONE;
                out_d.slot     = sp_rdata_i;
                if (sp_rdata_i != last_slot) begin
                  out_d.moved        = 1'b1;
                  out_d.moved_entity = dn_rdata_b_i;
                end
              end
            end
            default: begin
              if (present) begin
                out_d.status = ssit_pkg::STAT_DONE;
                out_d.slot   = sp_rdata_i;
              end
            end
          endcase
          out_d.used_count = count_d;
        end
      end
      default: begin
        state_d = ssit_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssit_pkg::ST_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      cmd_q <= in_data_i.command;
      ent_q <= in_data_i.entity;
    end
  end

endmodule

`default_nettype wire

// ===== src/ssit_checker.sv =====
// Port-level checker of the sparse set index table and its bind to the top level.
// Depends on ssit_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ssit_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire ssit_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire ssit_pkg::out_t out_data_o
);

  logic out_stall;
  logic in_fire;
  logic no_slot;
  logic moved_ok;

  assign out_stall = out_valid_o && !out_ready_i;
  assign in_fire   = in_valid_i && in_ready_o;
  assign no_slot   = out_valid_o && (out_data_o.status == ssit_pkg::STAT_ABSENT ||
                                     out_data_o.status == ssit_pkg::STAT_FULL);
  assign moved_ok  = (out_data_o.status == ssit_pkg::STAT_DONE) &&
                     (32'(out_data_o.used_count) < ssit_pkg::SLOTS);

  `SSIT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o))
  `SSIT_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_fire, !in_ready_o)
  `SSIT_ASSERT_NOW(a_slot_zero, clk_i, rst_ni, no_slot, out_data_o.slot == '0)
  `SSIT_ASSERT_NOW(a_moved_done, clk_i, rst_ni, out_valid_o && out_data_o.moved, moved_ok)

endmodule

bind sparse_set_index_table_top ssit_checker u_ssit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench of the sparse set index table: random and directed
// create, destroy and lookup transactions, with a scoreboard class that predicts every result.
// Depends on ssit_pkg and sparse_set_index_table_top.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ssit_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;

  class slot_table_scoreboard;
    logic [ENT_W-1:0]  ent_in_slot [SLOTS];
    logic [SLOT_W-1:0] slot_of [ENTITIES];
    int unsigned       live_count;
    out_t              awaited_replies [$];
    int                errors;

    function new();
      foreach (ent_in_slot[i]) ent_in_slot[i] = '0;
      foreach (slot_of[i]) slot_of[i] = '0;
      live_count = 0;
      errors = 0;
    endfunction

    function bit holds(logic [ENT_W-1:0] ent);
      return (slot_of[ent] < live_count) && (ent_in_slot[slot_of[ent]] == ent);
    endfunction

    function logic [ENT_W-1:0] any_entity();
      if (live_count > 0 && $urandom_range(1) == 1) begin
        return ent_in_slot[$urandom_range(live_count - 1)];
      end
      return ENT_W'($urandom_range(ENTITIES - 1));
    endfunction

    function void note_request(in_t req);
      out_t              rsp;
      bit                hit;
      logic [SLOT_W-1:0] hole;
      logic [SLOT_W-1:0] last;
      logic [ENT_W-1:0]  tail;
      rsp = '0;
      rsp.status = STAT_ABSENT;
      hit = holds(req.entity);
      case (req.command)
        CMD_CREATE: begin
          if (hit) begin
            rsp.status = STAT_PRESENT;
            rsp.slot = slot_of[req.entity];
          end else if (live_count >= SLOTS) begin
            rsp.status = STAT_FULL;
          end else begin
            rsp.slot = SLOT_W'(live_count);
            ent_in_slot[live_count] = req.entity;
            slot_of[req.entity] = SLOT_W'(live_count);
            live_count++;
            rsp.status = STAT_DONE;
          end
        end
        CMD_DESTROY: begin
          if (hit) begin
            hole = slot_of[req.entity];
            last = SLOT_W'(live_count - 1);
            tail = ent_in_slot[last];
            ent_in_slot[hole] = tail;
            slot_of[tail] = hole;
            live_count--;
            rsp.slot = hole;
            if (hole != last) begin
              rsp.moved = 1'b1;
              rsp.moved_entity = tail;
            end
            rsp.status = STAT_DONE;
          end
        end
        default: begin
          if (hit) begin
            rsp.status = STAT_DONE;
            rsp.slot = slot_of[req.entity];
          end
        end
      endcase
      rsp.used_count = CNT_W'(live_count);
      awaited_replies.push_back(rsp);
    endfunction

    function void check_response(out_t got);
      out_t exp;
      if (awaited_replies.size() == 0) begin
        $error("result transaction with no expectation waiting");
        errors++;
        return;
      end
      exp = awaited_replies.pop_front();
      if (got.status !== exp.status) begin
        $error("status expected %0d got %0d", exp.status, got.status);
        errors++;
      end
      if (got.slot !== exp.slot) begin
        $error("slot expected %0d got %0d", exp.slot, got.slot);
        errors++;
      end
      if (got.moved_entity !== exp.moved_entity) begin
        $error("moved_entity expected %0d got %0d", exp.moved_entity, got.moved_entity);
        errors++;
      end
      if (got.moved !== exp.moved) begin
        $error("moved expected %0d got %0d", exp.moved, got.moved);
        errors++;
      end
      if (got.used_count !== exp.used_count) begin
        $error("used_count expected %0d got %0d", exp.used_count, got.used_count);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  int send_idle = 37;
  int recv_idle = 65;

  slot_table_scoreboard sb = new();

  sparse_set_index_table_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_response(out_data_o);
    end
  end

  task automatic send(input logic [1:0] cmd, input logic [ENT_W-1:0] ent);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{command: cmd, entity: ent};
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(in_data_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.awaited_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_mixed(input int count, input int create_pct, input int destroy_pct);
    int         roll;
    logic [1:0] cmd;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < create_pct) begin
        cmd = CMD_CREATE;
      end else if (roll < create_pct + destroy_pct) begin
        cmd = CMD_DESTROY;
      end else begin
        cmd = ($urandom_range(7) == 0) ? CMD_SPARE : CMD_LOOKUP;
      end
      send(cmd, sb.any_entity());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(CMD_LOOKUP, 10'd0);
    send(CMD_DESTROY, 10'd0);
    send(CMD_CREATE, 10'd0);
    send(CMD_CREATE, 10'd1023);
    send(CMD_CREATE, 10'd0);
    send(CMD_LOOKUP, 10'd1023);
    send(CMD_SPARE, 10'd0);
    send(CMD_DESTROY, 10'd0);
    send(CMD_DESTROY, 10'd1023);
    send(CMD_LOOKUP, 10'd0);
    send(CMD_CREATE, 10'd5);
    send(CMD_CREATE, 10'd6);
    send(CMD_CREATE, 10'd7);
    send(CMD_DESTROY, 10'd7);
    send(CMD_DESTROY, 10'd5);
    send(CMD_SPARE, 10'd6);
    send(CMD_LOOKUP, 10'd7);
    send(CMD_DESTROY, 10'd6);
    send(CMD_DESTROY, 10'd6);
    send(CMD_CREATE, 10'd512);

    send_mixed(40, 50, 25);
    drain_results();

    send_idle = 65;
    recv_idle = 37;
    while (sb.live_count < SLOTS) begin
      send(CMD_CREATE, ($urandom_range(9) == 0) ? sb.any_entity()
                                                 : ENT_W'($urandom_range(ENTITIES - 1)));
    end
    for (int i = 0; i < 12; i++) begin
      send((i % 4 == 3) ? CMD_LOOKUP : CMD_CREATE, sb.any_entity());
    end
    send_mixed(20, 30, 50);
    drain_results();

    send_idle = 0;
    recv_idle = 0;
    while (sb.live_count > SLOTS / 2) begin
      if ($urandom_range(99) < 85) begin
        send(CMD_DESTROY, sb.ent_in_slot[$urandom_range(sb.live_count - 1)]);
      end else begin
        send(CMD_LOOKUP, sb.any_entity());
      end
    end
    send_mixed(30, 40, 30);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited_replies.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/ssit_pkg.sv
src/ssit_sparse_mem.sv
src/ssit_dense_mem.sv
src/ssit_ctrl.sv
src/sparse_set_index_table_top.sv
src/ssit_checker.sv
dv/testbench.sv
